[hw/rtl/fkm_pkg.sv]
// Package: shared constants, types and the byte folding function of the keyword matcher.
`timescale 1ns / 1ps
package fkm_pkg;

    localparam int MaxKeywords = 128;
    localparam int MaxKeyLen   = 32;
    localparam int KeyIdxW     = 7;
    localparam int PosW        = 5;
    localparam int LenW        = 6;
    localparam int StoreAw     = KeyIdxW + PosW;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    // Fold a raw byte: letters and Greek to capitals, digits kept, 0 kept, else '-'.
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = 8'h2D;
        if (c == 8'h00) begin
            r = 8'h00;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = c;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            r = c;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end else begin
            unique case (c)
                8'h80, 8'h98, 8'hE1:               r = 8'h41;
                8'h81, 8'h99:                      r = 8'h42;
                8'h82, 8'h9A:                      r = 8'h47;
                8'h83, 8'h9B:                      r = 8'h44;
                8'h84, 8'h9C, 8'hE2:               r = 8'h45;
                8'h85, 8'h9D:                      r = 8'h5A;
                8'h86, 8'h9E:                      r = 8'h49;
                8'h87, 8'h9F:                      r = 8'h54;
                8'h88, 8'hA0, 8'hE3, 8'hE4, 8'hE5: r = 8'h49;
                8'h89, 8'hA1:                      r = 8'h4B;
                8'h8A, 8'hA2:                      r = 8'h4C;
                8'h8B, 8'hA3:                      r = 8'h4D;
                8'h8C, 8'hA4:                      r = 8'h4E;
                8'h8D, 8'hA5, 8'h95, 8'hAE:        r = 8'h58;
                8'h8E, 8'hA6, 8'h97, 8'hE0,
                8'hE6, 8'hE9:                      r = 8'h4F;
                8'h8F, 8'hA7:                      r = 8'h50;
                8'h90, 8'hA8:                      r = 8'h52;
                8'h91, 8'hA9, 8'hAA:               r = 8'h53;
                8'h92, 8'hAB:                      r = 8'h54;
                8'h93, 8'hAC, 8'hE7, 8'hE8:        r = 8'h59;
                8'h94, 8'hAD:                      r = 8'h46;
                8'h96, 8'hAF:                      r = 8'h43;
                default:                           r = 8'h2D;
            endcase
        end
        return r;
    endfunction

    typedef struct packed {
        logic                 start;
        logic [7:0]           ch;
        logic [KeyIdxW:0]     count;
    } t_scan_cmd;

    typedef struct packed {
        logic               done;
        logic               found;
        logic [KeyIdxW-1:0] idx;
    } t_scan_sts;

endpackage

[hw/rtl/fkm_row_engine.sv]
// Row engine: walks keyword rows held in memories, updating partial-match state per text byte.
`timescale 1ns / 1ps
module fkm_row_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fkm_pkg::t_scan_cmd            i_cmd,
    input  logic                          i_clear,
    input  logic                          i_ld_we,
    input  logic [fkm_pkg::KeyIdxW-1:0]   i_ld_key,
    input  logic [fkm_pkg::PosW-1:0]      i_ld_pos,
    input  logic [7:0]                    i_ld_char,
    input  logic                          i_ld_last,
    output fkm_pkg::t_scan_sts            o_sts
);

    localparam int KW = fkm_pkg::KeyIdxW;
    localparam int KL = fkm_pkg::MaxKeyLen;

    // Keyword characters: one 32-byte row per keyword, byte-lane writes.
    logic [KL-1:0][7:0] keyrow_mem [fkm_pkg::MaxKeywords];
    logic [fkm_pkg::LenW-1:0] len_mem [fkm_pkg::MaxKeywords];
    logic [KL-1:0] pm_mem [fkm_pkg::MaxKeywords];
    logic [fkm_pkg::MaxKeywords-1:0] len_valid;
    logic [fkm_pkg::MaxKeywords-1:0] pm_valid;
    logic [fkm_pkg::MaxKeywords-1:0] seen;

    logic          r_busy, n_busy;
    logic [KW:0]   r_ctr;
    logic [7:0]    r_ch;
    logic [KW:0]   r_cnt;
    logic          r_rd_vld;
    logic [KW-1:0] r_rd_key;
    logic [KL-1:0][7:0] r_row;
    logic [fkm_pkg::LenW-1:0] r_len;
    logic          r_len_ok;
    logic [KL-1:0] r_pm;

    // Keyword and length memory writes, registered row read
    always_ff @(posedge i_clk) begin
        if (i_ld_we) begin
            keyrow_mem[i_ld_key][i_ld_pos] <= i_ld_char;
        end
        if (i_ld_we && i_ld_last) begin
            len_mem[i_ld_key] <= {1'b0, i_ld_pos} + 6'd1;
        end
        r_row    <= keyrow_mem[r_ctr[KW-1:0]];
        r_len    <= len_mem[r_ctr[KW-1:0]];
        r_len_ok <= len_valid[r_ctr[KW-1:0]];
        r_pm     <= pm_mem[r_ctr[KW-1:0]];
    end

    // Length written flags: a slot without one is an empty keyword
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            len_valid <= '0;
        end else if (i_ld_we && i_ld_last) begin
            len_valid[i_ld_key] <= 1'b1;
        end
    end

    // Row walk control
    always_comb begin
        n_busy = r_busy;
        if (i_cmd.start && i_cmd.count != '0) n_busy = 1'b1;
        else if (r_busy && r_ctr + 1'b1 >= r_cnt) n_busy = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ctr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_rd_vld <= r_busy;
            r_rd_key <= r_ctr[KW-1:0];
            if (i_cmd.start) begin
                r_ctr <= '0;
                r_ch  <= i_cmd.ch;
                r_cnt <= i_cmd.count;
            end else if (r_busy) begin
                r_ctr <= r_ctr + 1'b1;
            end
        end
    end

    // Modify: shift-and update of one row
    logic [KL-1:0] prev, pre_ok, nxt;
    logic [fkm_pkg::LenW-1:0] len;
    always_comb begin
        prev   = pm_valid[r_rd_key] ? r_pm : '0;
        pre_ok = {prev[KL-2:0], 1'b1};
        len    = r_len_ok ? r_len : '0;
        for (int i = 0; i < KL; i++) begin
            nxt[i] = (i < len) && (r_row[i] == r_ch) && pre_ok[i];
        end
    end

    // Write back the row and the seen flag
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) pm_mem[r_rd_key] <= nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            pm_valid <= '0;
            seen     <= '0;
        end else if (r_rd_vld) begin
            pm_valid[r_rd_key] <= 1'b1;
            if (len != '0 && nxt[len[fkm_pkg::PosW-1:0] - 1'b1]) seen[r_rd_key] <= 1'b1;
        end
    end

    // Lowest hit among active slots: seen flags and empty keywords
    logic [KW-1:0] hit_idx;
    logic          hit;
    always_comb begin
        hit = 1'b0;
        hit_idx = '0;
        for (int k = fkm_pkg::MaxKeywords - 1; k >= 0; k--) begin
            if (k < i_cmd.count && (seen[k] || !len_valid[k])) begin
                hit = 1'b1;
                hit_idx = KW'(k);
            end
        end
    end

    assign o_sts = {!r_busy && !r_rd_vld && !i_cmd.start, hit, hit_idx};

endmodule

[hw/rtl/folded_multi_keyword_matcher.sv]
// Top level: stream front end and sequencer of the folded multi-keyword matcher.
// Each scan beat walks the active keyword rows (keyword_count, capped at 128),
// one row per cycle through the row memories; a zero byte, a byte after it,
// or a byte with no active keyword walks no rows. Load beats start no walk.
// A result beat comes on the last scan byte of a record; one result may wait
// in the output register while input goes on, and the last byte of a later
// record is held until that result is taken. Input: tuser is operation;
// tdata holds key_index, char_position, char_value (bits 0..19); tlast is last.
`timescale 1ns / 1ps
module folded_multi_keyword_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // key_index, char_position, char_value
    input  logic        s_axis_tuser,   // operation
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // found, match_index
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic [7:0] r_kcount;
    logic       r_ended;
    logic       r_last;
    logic       r_out_vld;
    logic [7:0] r_out;

    fkm_pkg::t_scan_cmd cmd;
    fkm_pkg::t_scan_sts sts;

    logic                        in_op;
    logic [fkm_pkg::KeyIdxW-1:0] in_key;
    logic [fkm_pkg::PosW-1:0]    in_pos;
    logic [7:0]                  in_ch;
    assign in_op  = s_axis_tuser;
    assign in_key = s_axis_tdata[6:0];
    assign in_pos = s_axis_tdata[11:7];
    assign in_ch  = fkm_pkg::fold(s_axis_tdata[19:12]);

    logic acc, clear, out_free;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc         = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_vld || m_axis_tready;

    logic [7:0] act;
    assign act = (r_kcount > 8'(fkm_pkg::MaxKeywords)) ? 8'(fkm_pkg::MaxKeywords) : r_kcount;

    logic scan_live;
    assign scan_live = acc && in_op == fkm_pkg::OP_SCAN && !r_ended && in_ch != 8'h00;
    assign cmd = {scan_live, in_ch, act};

    // Sequencer: a record end waits in DONE while the output register is full
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (acc && in_op == fkm_pkg::OP_SCAN) n_state = ST_WALK;
            ST_WALK: n_state = ST_DONE;
            ST_DONE: if (sts.done && (!r_last || out_free)) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign clear = (r_state == ST_DONE) && sts.done && r_last && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_kcount  <= '0;
            r_ended   <= 1'b0;
            r_last    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_kcount <= i_cfg_data;
            if (acc && in_op == fkm_pkg::OP_SCAN) begin
                r_last <= s_axis_tlast;
                if (in_ch == 8'h00) r_ended <= 1'b1;
            end
            if (clear) begin
                r_out_vld <= 1'b1;
                r_out     <= {sts.idx, sts.found};
                r_ended   <= 1'b0;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out[7:1] & {7{r_out[0]}}, r_out[0]};

    fkm_row_engine u_rows (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_clear   (clear),
        .i_ld_we   (acc && in_op == fkm_pkg::OP_LOAD),
        .i_ld_key  (in_key),
        .i_ld_pos  (in_pos),
        .i_ld_char (in_ch),
        .i_ld_last (s_axis_tlast),
        .o_sts     (sts)
    );

    // A stalled result beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // Result appears only after a record end
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_last)) else $error("stray result");
    // Input is never ready outside the idle state
    a_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("ready during walk");

endmodule

[test/folded_multi_keyword_matcher_tb.sv]
// Testbench: directed and random stream checks of the folded multi-keyword matcher.
`timescale 1ns / 1ps
module folded_multi_keyword_matcher_tb;

    typedef logic [7:0] t_byte_q[$];

    typedef struct {
        logic                        found;
        logic [fkm_pkg::KeyIdxW-1:0] idx;
    } t_match_report;

    localparam int SettleCycles = 300;
    localparam int HoldOffCycles = 3000;
    localparam int IdleLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data = '0;
    logic        s_user = 1'b0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data = '0;
    wire         s_ready;
    wire         m_valid;
    wire  [7:0]  m_data;
    wire         cfg_ready;

    folded_multi_keyword_matcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mirror of the block state
    logic [7:0]  kw_folded [fkm_pkg::MaxKeywords][fkm_pkg::MaxKeyLen];
    logic [7:0]  kw_raw    [fkm_pkg::MaxKeywords][fkm_pkg::MaxKeyLen];
    int          kw_len    [fkm_pkg::MaxKeywords];
    logic [31:0] prefix_hits [fkm_pkg::MaxKeywords];
    bit          kw_seen   [fkm_pkg::MaxKeywords];
    bit          text_ended;
    int          active_kw;
    t_match_report pending_reports[$];

    int  errors = 0;
    int  reports_checked = 0;
    int  beats_sent = 0;
    bit  quiet_in = 0;
    bit  quiet_out = 0;
    bit  hold_req = 0;
    int  idle_cycles = 0;

    // Fold table: Greek letters in 0x80..0xAF and 0xE0..0xE9, ASCII letters and digits
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        string greek_lo;
        string greek_hi;
        greek_lo = "ABGDEZITIKLMNXOPRSTYFXCOABGDEZITIKLMNXOPRSSTYFXC";
        greek_hi = "OAEIIIOYYO";
        if (c == 8'h00) return 8'h00;
        if (c >= "0" && c <= "9") return c;
        if (c >= "A" && c <= "Z") return c;
        if (c >= "a" && c <= "z") return c - 8'h20;
        if (c >= 8'h80 && c <= 8'hAF) return greek_lo[c - 8'h80];
        if (c >= 8'hE0 && c <= 8'hE9) return greek_hi[c - 8'hE0];
        return "-";
    endfunction

    function automatic int count_limit();
        return (active_kw > fkm_pkg::MaxKeywords) ? fkm_pkg::MaxKeywords : active_kw;
    endfunction

    // Update the mirror with one accepted input beat
    task automatic predict_beat(input logic op, input int key, input int pos,
                                input logic [7:0] raw, input logic last);
        logic [7:0]    c;
        logic [31:0]   nxt;
        t_match_report rep;
        c = fold_byte(raw);
        if (op == fkm_pkg::OP_LOAD) begin
            kw_folded[key][pos] = c;
            kw_raw[key][pos] = raw;
            if (last) kw_len[key] = pos + 1;
            return;
        end
        if (!text_ended) begin
            if (c == 8'h00) begin
                text_ended = 1;
            end else begin
                for (int k = 0; k < count_limit(); k++) begin
                    nxt = '0;
                    for (int i = 0; i < kw_len[k]; i++)
                        if ((i == 0 || prefix_hits[k][i-1]) && kw_folded[k][i] == c)
                            nxt[i] = 1'b1;
                    prefix_hits[k] = nxt;
                    if (kw_len[k] > 0 && nxt[kw_len[k]-1]) kw_seen[k] = 1;
                end
            end
        end
        if (!last) return;
        rep.found = 1'b0;
        rep.idx = '0;
        for (int k = 0; k < count_limit(); k++) begin
            if (kw_seen[k] || kw_len[k] == 0) begin
                rep.found = 1'b1;
                rep.idx = k[fkm_pkg::KeyIdxW-1:0];
                break;
            end
        end
        pending_reports.push_back(rep);
        for (int k = 0; k < fkm_pkg::MaxKeywords; k++) begin
            prefix_hits[k] = '0;
            kw_seen[k] = 0;
        end
        text_ended = 0;
    endtask

    // Send one input beat and record its effect
    task automatic send_beat(input logic op, input int key, input int pos,
                             input logic [7:0] raw, input logic last);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {4'b0000, raw, pos[fkm_pkg::PosW-1:0], key[fkm_pkg::KeyIdxW-1:0]};
        s_user <= op;
        s_last <= last;
        do @(posedge i_clk); while (!s_ready);
        beats_sent++;
        predict_beat(op, key, pos, raw, last);
    endtask

    task automatic load_keyword(input int slot, input t_byte_q chars);
        foreach (chars[i])
            send_beat(fkm_pkg::OP_LOAD, slot, i, chars[i], i == chars.size() - 1);
    endtask

    task automatic scan_record(input t_byte_q text);
        foreach (text[i])
            send_beat(fkm_pkg::OP_SCAN, $urandom_range(0, 127), $urandom_range(0, 31),
                      text[i], i == text.size() - 1);
    endtask

    task automatic drain_reports();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // Register write only with the block idle
    task automatic write_count(input logic [7:0] value);
        drain_reports();
        repeat (SettleCycles) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        active_kw = int'(value);
    endtask

    // Result side: random stalls, optional long hold-off, compare each beat
    initial begin : result_sink
        int            stall;
        t_match_report want;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge i_clk);
                hold_req = 0;
            end
            stall = quiet_out ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
            reports_checked++;
            if (pending_reports.size() == 0) begin
                $error("result beat 0x%02h with no record pending", m_data);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                if (m_data[0] !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_data[0]);
                    errors++;
                end
                if (m_data[7:1] !== want.idx) begin
                    $error("match_index: expected %0d, got %0d", want.idx, m_data[7:1]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("folded_multi_keyword_matcher test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_directed();
        t_byte_q t;
        // no active keyword: nothing found
        scan_record('{"a", "b"});
        load_keyword(0, '{"C", "a", "t"});
        load_keyword(1, '{8'h98, "b", "9"});
        load_keyword(2, '{8'hFF, "Z"});
        load_keyword(4, '{"A", 8'h00});
        write_count(8'd3);
        scan_record('{"x", "c", "A", "t"});
        scan_record('{8'hE1, "B", "9"});
        // zero byte ends the live text
        scan_record('{"q", 8'h00, "C", "A", "T"});
        scan_record('{"!", "z"});
        // keyword loaded while a record is open
        send_beat(fkm_pkg::OP_SCAN, 0, 0, "c", 1'b0);
        load_keyword(1, '{"Q"});
        t = '{"a", "t"};
        scan_record(t);
        // empty slot 3 matches everything
        write_count(8'd5);
        scan_record('{"q"});
        write_count(8'd0);
        scan_record('{8'h00});
    endtask

    task automatic load_all_keywords();
        t_byte_q kw;
        int      len;
        for (int k = 0; k < fkm_pkg::MaxKeywords; k++) begin
            len = (k == 77) ? fkm_pkg::MaxKeyLen : $urandom_range(2, 5);
            kw = {};
            for (int i = 0; i < len; i++)
                kw.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range("a", "z")));
            load_keyword(k, kw);
        end
    endtask

    task automatic random_records(input int beats);
        t_byte_q text;
        int      start;
        int      slot;
        int      lim;
        start = beats_sent;
        lim = count_limit();
        while (beats_sent - start < beats) begin
            text = {};
            repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(1, 255)));
            if (lim > 0 && $urandom_range(0, 9) < 7) begin
                slot = $urandom_range(0, lim - 1);
                for (int i = 0; i < kw_len[slot] && i < 8; i++)
                    text.push_back(($urandom_range(0, 1) && kw_raw[slot][i] >= "a"
                                    && kw_raw[slot][i] <= "z") ? kw_raw[slot][i] - 8'h20
                                                              : kw_raw[slot][i]);
            end
            repeat ($urandom_range(0, 4))
                text.push_back(($urandom_range(0, 15) == 0) ? 8'h00
                                                            : 8'($urandom_range(0, 255)));
            if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 19) == 0) begin
                slot = $urandom_range(0, 127);
                send_beat(fkm_pkg::OP_LOAD, slot, 0, 8'($urandom_range("a", "z")), 1'b0);
            end
            scan_record(text);
            quiet_in = ($urandom_range(0, 9) == 0);
            quiet_out = ($urandom_range(0, 9) == 0);
        end
        quiet_in = 0;
        quiet_out = 0;
    endtask

    task automatic test_random();
        load_all_keywords();
        write_count(8'd128);
        random_records(200);
        write_count(8'd255);
        random_records(150);
        write_count(8'($urandom_range(1, 127)));
        random_records(200);
        write_count(8'd6);
        random_records(200);
    endtask

    task automatic test_pressure();
        // receiver holds off while the sender keeps offering beats
        write_count(8'd16);
        hold_req = 1;
        quiet_in = 1;
        random_records(60);
        quiet_in = 0;
        // sender waits for all pending results, then sends more records
        drain_reports();
        random_records(40);
    endtask

    initial begin : main
        for (int k = 0; k < fkm_pkg::MaxKeywords; k++) begin
            kw_len[k] = 0;
            prefix_hits[k] = '0;
            kw_seen[k] = 0;
        end
        text_ended = 0;
        active_kw = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_pressure();
        drain_reports();
        repeat (SettleCycles) @(posedge i_clk);
        $display("Covered %0d input beats and %0d record results over keyword counts", beats_sent,
                 reports_checked);
        $display("0, 3, 5, 6, 16, 128, 255 and one random count, with stalls and a hold-off.");
        if (errors == 0 && pending_reports.size() == 0) begin
            $display("folded_multi_keyword_matcher test passed");
        end else begin
            $display("folded_multi_keyword_matcher test failed");
        end
        $finish;
    end
endmodule
